/* design/ps2_mouse_packet_decoder_unit_defines.svh */
// Assertion macros shared by the PS/2 mouse packet decoder RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PS2MD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PS2MD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ps2md_pkg.sv */
// Package for the PS/2 mouse packet decoder: widths, mouse type codes, byte masks,
// wheel and step codes, byte positions and the result struct. No dependencies.
`timescale 1ns / 1ps

package ps2md_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned RESULT_W   = 28;
    localparam int unsigned OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        TYPE_BASIC  = 2'd0,
        TYPE_SCROLL = 2'd1,
        TYPE_FIVE   = 2'd2,
        TYPE_UNUSED = 2'd3
    } mouse_type_t;

    localparam logic [1:0] POS_STATUS = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;
    localparam logic [1:0] POS_BONUS  = 2'd3;

    localparam logic [7:0] OVERFLOW_BITS     = 8'hC0;
    localparam logic [7:0] BASIC_BUTTON_BITS = 8'h07;
    localparam logic [7:0] X_SIGN_BIT        = 8'h10;
    localparam logic [7:0] Y_SIGN_BIT        = 8'h20;
    localparam logic [7:0] EXTRA_BUTTON_BITS = 8'h30;

    localparam logic [3:0] WHEEL_NONE  = 4'h0;
    localparam logic [3:0] WHEEL_UP    = 4'h1;
    localparam logic [3:0] WHEEL_RIGHT = 4'h2;
    localparam logic [3:0] WHEEL_LEFT  = 4'hE;
    localparam logic [3:0] WHEEL_DOWN  = 4'hF;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_PLUS = 2'b01;
    localparam logic [1:0] STEP_MINUS = 2'b11;

    typedef struct packed {
        logic       wheel_code_unexpected;
        logic [1:0] wheel_horizontal;
        logic [1:0] wheel_vertical;
        logic [8:0] delta_y;
        logic [8:0] delta_x;
        logic [4:0] buttons;
    } result_t;

endpackage

/* design/ps2_mouse_packet_decoder_unit.sv */
// Top level of the PS/2 mouse packet decoder: byte stream in, packet stream out.
// Depends on ps2md_pkg and ps2_mouse_packet_decoder_unit_defines.svh.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_decoder_unit_defines.svh"

// Usage
// The slave stream carries one mouse byte per transfer. The master stream
// carries one decoded packet per transfer, after the third byte of a packet
// (basic mouse) or the fourth (scroll and five-button mice); packets whose
// status byte has an overflow bit set give no transfer.
// cfg_we writes mouse_type from cfg_wdata; write it only while the block idles.
// The packet appears on the master side in the cycle after its last byte is
// transferred in. Throughput: one byte per cycle, limited only by the
// single output register, which is reloaded in the cycle it is drained.
// While the master side stalls with a packet pending, bytes that complete no
// packet are still taken; a byte that would complete one waits for the drain.
// Reset clears the byte position, the stored bytes, the mouse type (basic)
// and the output valid flag; the next byte is taken as a status byte.
// Framing is never recovered: the byte counter simply wraps per packet.
module ps2_mouse_packet_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,     // mouse_type
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // buttons[4:0], delta_x[13:5], delta_y[22:14],
                                       // wheel_vertical[24:23], wheel_horizontal[26:25],
                                       // wheel_code_unexpected[27], zero[31:28]
);

    ps2md_pkg::mouse_type_t mouse_type_reg;
    logic [1:0]             pos_reg, pos_next;
    logic [7:0]             status_reg;
    logic [7:0]             x_reg;
    logic [7:0]             y_reg;
    logic                   out_valid_reg;
    ps2md_pkg::result_t     out_data_reg, result_next;

    logic       has_wheel;
    logic       last_byte;
    logic       emit;
    logic       s_fire;
    logic [7:0] y_byte;
    logic [7:0] bonus;
    logic [3:0] nibble;

    assign has_wheel = (mouse_type_reg == ps2md_pkg::TYPE_SCROLL) ||
                       (mouse_type_reg == ps2md_pkg::TYPE_FIVE);
    assign last_byte = ((pos_reg == ps2md_pkg::POS_Y) && !has_wheel) ||
                       (pos_reg == ps2md_pkg::POS_BONUS);
    assign emit      = last_byte && ((status_reg & ps2md_pkg::OVERFLOW_BITS) == 8'h00);

    // A byte that completes no packet never touches the output register.
    assign s_tready = !out_valid_reg || m_tready || !emit;
    assign s_fire   = s_tvalid && s_tready;

    assign y_byte = (pos_reg == ps2md_pkg::POS_Y) ? s_tdata : y_reg;
    assign bonus  = (pos_reg == ps2md_pkg::POS_BONUS) ? s_tdata : 8'h00;
    assign nibble = bonus[3:0];

    always_comb
    begin
        pos_next = pos_reg;
        case (pos_reg)
            ps2md_pkg::POS_STATUS: pos_next = ps2md_pkg::POS_X;
            ps2md_pkg::POS_X:      pos_next = ps2md_pkg::POS_Y;
            ps2md_pkg::POS_Y:      pos_next = has_wheel ? ps2md_pkg::POS_BONUS
                                                        : ps2md_pkg::POS_STATUS;
            default:               pos_next = ps2md_pkg::POS_STATUS;
        endcase
    end

    always_comb
    begin
        result_next = '0;
        result_next.buttons = {2'b00, status_reg[2:0] & ps2md_pkg::BASIC_BUTTON_BITS[2:0]};
        if (mouse_type_reg == ps2md_pkg::TYPE_FIVE)
        begin
            result_next.buttons[4:3] = bonus[5:4] & ps2md_pkg::EXTRA_BUTTON_BITS[5:4];
        end
        result_next.delta_x = {((status_reg & ps2md_pkg::X_SIGN_BIT) != 8'h00), x_reg};
        result_next.delta_y = {((status_reg & ps2md_pkg::Y_SIGN_BIT) != 8'h00), y_byte};
        if (has_wheel)
        begin
            case (nibble)
                ps2md_pkg::WHEEL_NONE:  ;
                ps2md_pkg::WHEEL_UP:    result_next.wheel_vertical   = ps2md_pkg::STEP_PLUS;
                ps2md_pkg::WHEEL_DOWN:  result_next.wheel_vertical   = ps2md_pkg::STEP_MINUS;
                ps2md_pkg::WHEEL_LEFT:  result_next.wheel_horizontal = ps2md_pkg::STEP_MINUS;
                ps2md_pkg::WHEEL_RIGHT: result_next.wheel_horizontal = ps2md_pkg::STEP_PLUS;
                default:                result_next.wheel_code_unexpected = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouse_type_reg <= ps2md_pkg::TYPE_BASIC;
            pos_reg        <= ps2md_pkg::POS_STATUS;
            status_reg     <= 8'h00;
            x_reg          <= 8'h00;
            y_reg          <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mouse_type_reg <= ps2md_pkg::mouse_type_t'(cfg_wdata);
            end
            if (s_fire)
            begin
                pos_reg <= pos_next;
                case (pos_reg)
                    ps2md_pkg::POS_STATUS: status_reg <= s_tdata;
                    ps2md_pkg::POS_X:      x_reg      <= s_tdata;
                    ps2md_pkg::POS_Y:      y_reg      <= s_tdata;
                    default:               ;
                endcase
            end
            if (s_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && emit)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ps2md_pkg::OUT_DATA_W - ps2md_pkg::RESULT_W){1'b0}}, out_data_reg};

    `PS2MD_ASSERT_NEXT(a_emit_loads_output, s_fire && emit, out_valid_reg,
        "completed packet did not reach the output register")
    `PS2MD_ASSERT_NEXT(a_status_advances, s_fire && (pos_reg == ps2md_pkg::POS_STATUS),
        pos_reg == ps2md_pkg::POS_X, "status byte did not advance the byte position")
    `PS2MD_ASSERT_NOW(a_one_wheel_axis, out_valid_reg,
        (out_data_reg.wheel_vertical == ps2md_pkg::STEP_NONE) ||
        (out_data_reg.wheel_horizontal == ps2md_pkg::STEP_NONE),
        "both wheel axes moved in one packet")
    `PS2MD_ASSERT_NOW(a_odd_code_still, out_valid_reg && out_data_reg.wheel_code_unexpected,
        (out_data_reg.wheel_vertical == ps2md_pkg::STEP_NONE) &&
        (out_data_reg.wheel_horizontal == ps2md_pkg::STEP_NONE),
        "unexpected wheel code produced movement")

endmodule
